[rtl/cds_complement_range_parser_top_assert.svh]
// Assertion macros used by the checker file.
`ifndef CDS_COMPLEMENT_RANGE_PARSER_TOP_ASSERT_SVH
`define CDS_COMPLEMENT_RANGE_PARSER_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define CDSCRP_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("cdscrp assertion failed");

// Next-cycle implication, disabled while reset is low.
`define CDSCRP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("cdscrp assertion failed");

`endif

[rtl/cdscrp_pkg.sv]
`default_nettype none
package cdscrp_pkg;

    localparam int OUT_BITS = 32;
    localparam int WORD_LEN = 10;

    // line mark codes
    localparam logic [2:0] MARK_AWAIT_C = 3'd0;
    localparam logic [2:0] MARK_GOT_C   = 3'd1;
    localparam logic [2:0] MARK_GOT_D   = 3'd2;
    localparam logic [2:0] MARK_IN_CDS  = 3'd3;
    localparam logic [2:0] MARK_SKIP    = 3'd4;

    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_VT     = 8'h0B;
    localparam logic [7:0] CH_FF     = 8'h0C;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SP     = 8'h20;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_0      = 8'h30;
    localparam logic [7:0] CH_9      = 8'h39;
    localparam logic [7:0] CH_UC_C   = 8'h43;
    localparam logic [7:0] CH_UC_D   = 8'h44;
    localparam logic [7:0] CH_UC_S   = 8'h53;

    localparam logic [3:0] MATCH_DONE = 4'(WORD_LEN);

    function automatic logic is_blank(input logic [7:0] c);
        return c inside {CH_SP, CH_TAB, CH_CR, CH_VT, CH_FF};
    endfunction

    // letters of "complement"
    function automatic logic [7:0] keyword_char(input logic [3:0] idx);
        logic [7:0] ch;
        case (idx)
            4'd0:    ch = 8'h63; // c
            4'd1:    ch = 8'h6F; // o
            4'd2:    ch = 8'h6D; // m
            4'd3:    ch = 8'h70; // p
            4'd4:    ch = 8'h6C; // l
            4'd5:    ch = 8'h65; // e
            4'd6:    ch = 8'h6D; // m
            4'd7:    ch = 8'h65; // e
            4'd8:    ch = 8'h6E; // n
            4'd9:    ch = 8'h74; // t
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage
`default_nettype wire

[rtl/cds_complement_range_parser_top.sv]
// A record appears on the master side in the cycle after the byte that causes it is accepted.
// Throughput: one byte per cycle; the only stall is a result held by m_tready low.
// Parse state and accumulators update in the accept cycle; the result register
// decouples the two sides.
// Reset: synchronous, active low; clears parse state and the result valid.
`default_nettype none
module cds_complement_range_parser_top
    import cdscrp_pkg::*;
#(
    parameter int COORD_BITS = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_tvalid,
    output      logic        s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] in_byte
    input  wire logic [0:0]  s_tuser,   // [0] end_of_file
    output      logic        m_tvalid,
    input  wire logic        m_tready,
    output      logic [63:0] m_tdata,   // [31:0] start_coord, [63:32] end_coord
    output      logic        m_tlast    // list_end
);

    logic [2:0]            r_mark, n_mark;
    logic                  r_als, n_als;
    logic [3:0]            r_mc, n_mc;
    logic                  r_pd, n_pd;
    logic [COORD_BITS-1:0] r_sa, n_sa;
    logic [COORD_BITS-1:0] r_ea, n_ea;

    logic                  r_out_valid;
    logic [OUT_BITS-1:0]   r_out_start;
    logic [OUT_BITS-1:0]   r_out_end;
    logic                  r_out_last;

    logic                  s_accept;
    logic                  emit;
    logic                  emit_last;
    logic [7:0]            c;
    logic [3:0]            digit;
    logic [63:0]           sa_ext;
    logic [63:0]           ea_ext;

    // acc*10 + d, saturating at all ones
    function automatic logic [COORD_BITS-1:0] push_digit(
        input logic [COORD_BITS-1:0] acc,
        input logic [3:0]            d
    );
        logic [COORD_BITS+3:0] sum;
        sum = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + (COORD_BITS+4)'(d);
        if (sum[COORD_BITS+3:COORD_BITS] != 4'd0) begin
            return {COORD_BITS{1'b1}};
        end
        return sum[COORD_BITS-1:0];
    endfunction

    assign s_tready = !r_out_valid || m_tready;
    assign s_accept = s_tvalid && s_tready;
    assign c        = s_tdata;
    assign digit    = 4'(c - CH_0);
    assign sa_ext   = 64'(r_sa);
    assign ea_ext   = 64'(r_ea);

    always_comb begin
        n_mark    = r_mark;
        n_als     = r_als;
        n_mc      = r_mc;
        n_pd      = r_pd;
        n_sa      = r_sa;
        n_ea      = r_ea;
        emit      = 1'b0;
        emit_last = 1'b0;
        if (s_tuser[0]) begin
            emit      = 1'b1;
            emit_last = 1'b1;
            n_mark    = MARK_AWAIT_C;
            n_als     = 1'b1;
            n_mc      = 4'd0;
            n_pd      = 1'b0;
            n_sa      = '0;
            n_ea      = '0;
        end else if (c == CH_LF) begin
            n_als  = 1'b1;
            n_mark = MARK_AWAIT_C;
        end else if (r_mark >= MARK_SKIP) begin
            // rest of an ignored line
        end else if (r_als && r_mark != MARK_IN_CDS) begin
            if (!is_blank(c)) begin
                if (r_mark == MARK_AWAIT_C && c == CH_UC_C) begin
                    n_mark = MARK_GOT_C;
                end else if (r_mark == MARK_GOT_C && c == CH_UC_D) begin
                    n_mark = MARK_GOT_D;
                end else if (r_mark == MARK_GOT_D && c == CH_UC_S) begin
                    n_mark = MARK_IN_CDS;
                end else begin
                    n_mark = MARK_SKIP;
                    n_als  = 1'b0;
                end
            end
        end else if (r_mark == MARK_IN_CDS) begin
            n_als = 1'b0;
            if (is_blank(c)) begin
                // blanks are not collected
            end else if (c == CH_RPAREN) begin
                emit = (r_mc >= MATCH_DONE);
                n_mc = 4'd0;
                n_pd = 1'b0;
                n_sa = '0;
                n_ea = '0;
            end else if (r_mc < MATCH_DONE) begin
                if (c == keyword_char(r_mc)) begin
                    n_mc = r_mc + 4'd1;
                end else begin
                    n_mc = (c == keyword_char(4'd0)) ? 4'd1 : 4'd0;
                end
            end else if (c == CH_DOT) begin
                n_pd = 1'b1;
            end else if (c inside {[CH_0:CH_9]}) begin
                if (r_pd) begin
                    n_ea = push_digit(r_ea, digit);
                end else begin
                    n_sa = push_digit(r_sa, digit);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mark      <= MARK_AWAIT_C;
            r_als       <= 1'b1;
            r_mc        <= 4'd0;
            r_pd        <= 1'b0;
            r_sa        <= '0;
            r_ea        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (s_accept) begin
                r_mark      <= n_mark;
                r_als       <= n_als;
                r_mc        <= n_mc;
                r_pd        <= n_pd;
                r_sa        <= n_sa;
                r_ea        <= n_ea;
                r_out_valid <= emit;
            end else if (m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload, no reset
    always_ff @(posedge i_clk) begin
        if (s_accept && emit) begin
            r_out_last <= emit_last;
            if (emit_last) begin
                r_out_start <= '0;
                r_out_end   <= '0;
            end else begin
                r_out_start <= sa_ext[OUT_BITS-1:0];
                r_out_end   <= ea_ext[OUT_BITS-1:0];
            end
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = {r_out_end, r_out_start};
    assign m_tlast  = r_out_last;

endmodule
`default_nettype wire

[rtl/cdscrp_checker.sv]
`default_nettype none
`include "cds_complement_range_parser_top_assert.svh"
module cdscrp_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_s_tvalid,
    input wire logic        i_s_tready,
    input wire logic [0:0]  i_s_tuser,
    input wire logic        i_m_tvalid,
    input wire logic        i_m_tready,
    input wire logic [63:0] i_m_tdata,
    input wire logic        i_m_tlast
);

    // a stalled result holds
    `CDSCRP_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_m_tvalid && !i_m_tready, i_m_tvalid && $stable(i_m_tdata) && $stable(i_m_tlast))

    // terminator carries zero coordinates
    `CDSCRP_ASSERT_NOW(a_term_zero, i_clk, i_rst_n, i_m_tvalid && i_m_tlast, i_m_tdata == 64'd0)

    // end-of-file transaction yields a terminator in the next cycle
    `CDSCRP_ASSERT_NEXT(a_eof_term, i_clk, i_rst_n, i_s_tvalid && i_s_tready && i_s_tuser[0], i_m_tvalid && i_m_tlast)

    // input side only waits on a stalled result
    `CDSCRP_ASSERT_NOW(a_ready_free, i_clk, i_rst_n, !i_m_tvalid || i_m_tready, i_s_tready)

    `CDSCRP_ASSERT_NOW(a_ready_stall, i_clk, i_rst_n, i_m_tvalid && !i_m_tready, !i_s_tready)

endmodule

bind cds_complement_range_parser_top cdscrp_checker u_cdscrp_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (s_tvalid),
    .i_s_tready (s_tready),
    .i_s_tuser  (s_tuser),
    .i_m_tvalid (m_tvalid),
    .i_m_tready (m_tready),
    .i_m_tdata  (m_tdata),
    .i_m_tlast  (m_tlast)
);
`default_nettype wire

[tb/tb.sv]
`timescale 1ns / 1ps
module tb;
    import cdscrp_pkg::*;

    localparam int          CLK_PERIOD  = 12;
    localparam int          CYCLE_LIMIT = 400000;
    localparam logic [79:0] KEYWORD     = "complement";
    localparam logic [31:0] COORD_MAX   = '1;

    typedef struct packed {
        logic [31:0] start_coord;
        logic [31:0] end_coord;
        logic        list_end;
    } range_rec_t;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;   // [7:0] in_byte
    logic [0:0]  s_tuser;   // [0] end_of_file
    logic        m_tvalid;
    logic        m_tready;
    logic [63:0] m_tdata;   // [31:0] start_coord, [63:32] end_coord
    logic        m_tlast;   // list_end

    range_rec_t  range_q[$];
    logic [7:0]  text_q[$];
    int          fail_count;
    int          sent_count;
    bit          stall_enable;

    // parser state mirrored by the predictor
    logic [2:0]  mark;
    logic        line_start;
    logic [3:0]  kw_hits;
    logic        dot_seen;
    logic [31:0] start_acc;
    logic [31:0] end_acc;

    cds_complement_range_parser_top dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("Regression FAIL");
        $finish;
    end

    // ---------------- predictor ----------------

    function automatic logic blank_char(input logic [7:0] c);
        return c == CH_SP || c == CH_TAB || c == CH_CR || c == CH_VT || c == CH_FF;
    endfunction

    function automatic logic [7:0] kw_letter(input int idx);
        return KEYWORD[79 - 8 * idx -: 8];
    endfunction

    // decimal shift-in, pinned at all ones on overflow
    function automatic logic [31:0] add_digit(input logic [31:0] acc, input logic [7:0] c);
        logic [35:0] wide;
        wide = 36'(acc) * 36'd10 + 36'(c - CH_0);
        return (wide > 36'(COORD_MAX)) ? COORD_MAX : wide[31:0];
    endfunction

    task automatic clear_scan();
        kw_hits   = '0;
        dot_seen  = 1'b0;
        start_acc = '0;
        end_acc   = '0;
    endtask

    task automatic reset_predictor();
        mark       = MARK_AWAIT_C;
        line_start = 1'b1;
        clear_scan();
    endtask

    task automatic predict_range(input logic [7:0] c, input logic eof);
        if (eof) begin
            range_q.push_back('{start_coord: '0, end_coord: '0, list_end: 1'b1});
            reset_predictor();
        end else if (c == CH_LF) begin
            line_start = 1'b1;
            mark       = MARK_AWAIT_C;
        end else if (mark < MARK_SKIP) begin
            if (line_start && mark != MARK_IN_CDS) begin
                if (!blank_char(c)) begin
                    if (mark == MARK_AWAIT_C && c == CH_UC_C) begin
                        mark = MARK_GOT_C;
                    end else if (mark == MARK_GOT_C && c == CH_UC_D) begin
                        mark = MARK_GOT_D;
                    end else if (mark == MARK_GOT_D && c == CH_UC_S) begin
                        mark = MARK_IN_CDS;
                    end else begin
                        mark       = MARK_SKIP;
                        line_start = 1'b0;
                    end
                end
            end else if (mark == MARK_IN_CDS) begin
                line_start = 1'b0;
                if (!blank_char(c)) begin
                    if (c == CH_RPAREN) begin
                        if (kw_hits >= MATCH_DONE)
                            range_q.push_back('{start_coord: start_acc, end_coord: end_acc,
                                                list_end: 1'b0});
                        clear_scan();
                    end else if (kw_hits < MATCH_DONE) begin
                        if (c == kw_letter(int'(kw_hits)))
                            kw_hits = kw_hits + 4'd1;
                        else
                            kw_hits = (c == kw_letter(0)) ? 4'd1 : 4'd0;
                    end else if (c == CH_DOT) begin
                        dot_seen = 1'b1;
                    end else if (c >= CH_0 && c <= CH_9) begin
                        if (dot_seen)
                            end_acc = add_digit(end_acc, c);
                        else
                            start_acc = add_digit(start_acc, c);
                    end
                end
            end
        end
    endtask

    // ---------------- stimulus ----------------

    task automatic send_item(input logic [7:0] c, input logic eof);
        if (stall_enable && $urandom_range(0, 9) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tuser  <= eof;
        do @(posedge i_clk); while (!s_tready);
        predict_range(c, eof);
        sent_count++;
        @(negedge i_clk);
    endtask

    task automatic queue_str(input string t);
        for (int i = 0; i < t.len(); i++)
            text_q.push_back(t[i]);
    endtask

    task automatic queue_blanks(input int n);
        repeat (n) begin
            case ($urandom_range(0, 4))
                0:       text_q.push_back(CH_TAB);
                1:       text_q.push_back(CH_CR);
                2:       text_q.push_back(CH_VT);
                3:       text_q.push_back(CH_FF);
                default: text_q.push_back(CH_SP);
            endcase
        end
    endtask

    task automatic queue_digits(input int n);
        repeat (n) text_q.push_back(CH_0 + 8'($urandom_range(0, 9)));
    endtask

    // optional blanks before and between the three letters, at least one blank after them
    task automatic queue_cds_head();
        queue_blanks($urandom_range(0, 2));
        queue_str("C");
        queue_blanks($urandom_range(0, 1));
        queue_str("D");
        queue_blanks($urandom_range(0, 1));
        queue_str("S");
        queue_blanks($urandom_range(1, 3));
    endtask

    task automatic flush_text();
        while (text_q.size() != 0)
            send_item(text_q.pop_front(), 1'b0);
    endtask

    task automatic send_text(input string t);
        queue_str(t);
        flush_text();
    endtask

    // drop valid and hold off until every record has come back
    task automatic drain_sender();
        s_tvalid <= 1'b0;
        while (range_q.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    function automatic int digit_count();
        return ($urandom_range(0, 19) == 0) ? $urandom_range(10, 14) : $urandom_range(0, 6);
    endfunction

    // ---------------- tests ----------------

    task automatic test_basic_record();
        send_text("CDS complement(12..345)\n");
    endtask

    task automatic test_line_filter();
        send_text(" C\tD S  complement(7.8)\n");
        send_text("gene complement(1.2)\n");
        send_text("CDX complement(3.4)\n");
    endtask

    task automatic test_special_cases();
        // keyword split over lines, foreign line in between, nested parens
        send_text("CDS join(comple\nmisc ment\nCDS ment(5.6))\n");
        send_text("CDS join(1.2)\n");
        send_text("CDS complement(99)\n");
        send_text("CDS complement(1.2.3)\n");
        send_text("CDS complement(99999999999.4294967296)\n");
        send_text("CDS complement(4294967295.0)\n");
        send_text("CDS complement(");
        send_item(8'h00, 1'b0);
        send_item(8'hFF, 1'b0);
        send_text("2.3)\n");
    endtask

    task automatic test_eof_restart();
        send_text("CDS complem");
        send_item(8'($urandom), 1'b1);
        send_text("ent(1.2)\n");
        send_text("CDS complement(8.9)\n");
        send_item(8'($urandom), 1'b1);
    endtask

    task automatic test_drain_pause();
        send_text("CDS complement(40.41)\n");
        drain_sender();
        send_text("CDS complement(42.43)\n");
        drain_sender();
    endtask

    task automatic test_random_files(input int n_items);
        int goal;
        int pick;
        goal = sent_count + n_items;
        while (sent_count < goal) begin
            pick = $urandom_range(0, 99);
            if (pick < 60) begin
                queue_cds_head();
                if (pick < 15)
                    queue_str("join(");
                if (pick % 7 == 0)
                    queue_str("ccompl");
                queue_str("complement(");
                queue_digits(digit_count());
                if (pick % 5 != 0) begin
                    if (pick % 3 == 0)
                        queue_str("..");
                    else
                        queue_str(".");
                end
                queue_digits(digit_count());
                if (pick % 11 == 0) begin
                    // range continues on the next CDS line
                    queue_str("\n");
                    queue_cds_head();
                    queue_digits(digit_count());
                end
                queue_str(")");
                if (pick % 4 == 0)
                    queue_str(")");
                queue_blanks($urandom_range(0, 2));
                queue_str("\n");
            end else if (pick < 72) begin
                queue_blanks($urandom_range(0, 2));
                if (pick % 2 == 0)
                    queue_str("gene complement(12..34)\n");
                else
                    queue_str("CDX complement(56..78)\n");
            end else if (pick < 82) begin
                queue_cds_head();
                if (pick % 2 == 0)
                    queue_str("complemen(5.6)\n");
                else
                    queue_str("compXlement(7.8)\n");
            end else if (pick < 96) begin
                repeat ($urandom_range(1, 8)) text_q.push_back(8'($urandom));
            end else begin
                flush_text();
                send_item(8'($urandom), 1'b1);
            end
            flush_text();
        end
    endtask

    // ---------------- checking ----------------

    always @(posedge i_clk) begin : check_records
        range_rec_t want;
        if (i_rst_n && m_tvalid && m_tready) begin
            if (range_q.size() == 0) begin
                $error("unexpected record: start_coord %0d end_coord %0d list_end %0b",
                       m_tdata[31:0], m_tdata[63:32], m_tlast);
                fail_count++;
            end else begin
                want = range_q.pop_front();
                if (m_tdata[31:0] !== want.start_coord) begin
                    $error("start_coord: expected %0d, actual %0d",
                           want.start_coord, m_tdata[31:0]);
                    fail_count++;
                end
                if (m_tdata[63:32] !== want.end_coord) begin
                    $error("end_coord: expected %0d, actual %0d",
                           want.end_coord, m_tdata[63:32]);
                    fail_count++;
                end
                if (m_tlast !== want.list_end) begin
                    $error("list_end: expected %0b, actual %0b", want.list_end, m_tlast);
                    fail_count++;
                end
            end
        end
    end

    // result side back-pressure
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall_enable && $urandom_range(0, 7) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(negedge i_clk);
            end
            m_tready <= 1'b1;
        end
    end

    initial begin
        i_rst_n      = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = '0;
        fail_count   = 0;
        sent_count   = 0;
        stall_enable = 1'b1;
        reset_predictor();
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_basic_record();
        test_line_filter();
        test_special_cases();
        test_eof_restart();
        test_drain_pause();
        test_random_files(1000);
        stall_enable = 1'b0;
        test_random_files(250);

        drain_sender();
        repeat (8) @(posedge i_clk);
        if (range_q.size() == 0 && fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

[cds_complement_range_parser_top.f]
+incdir+rtl
rtl/cdscrp_pkg.sv
rtl/cds_complement_range_parser_top.sv
rtl/cdscrp_checker.sv
tb/tb.sv
